[design/scheduled_pwm_generator_unit_defines.svh]
// ----------------------------------------------------------------------------
// Scheduled PWM generator assertion macros
// Shared concurrent assertion forms, clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef SCHEDULED_PWM_GENERATOR_UNIT_DEFINES_SVH
`define SCHEDULED_PWM_GENERATOR_UNIT_DEFINES_SVH

// checked only out of reset
`define SPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// checked at every edge, reset included
`define SPG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

[design/spg_pkg.sv]
// ----------------------------------------------------------------------------
// Scheduled PWM generator package
// Widths, register indexes, mode flag bits, error codes and time compare.
// ----------------------------------------------------------------------------
`default_nettype none

package spg_pkg;

    localparam int TIME_W    = 32;
    localparam int MODE_W    = 7;
    localparam int CFG_IDX_W = 8;
    localparam int OUT_W     = 8;

    localparam logic [TIME_W-1:0] CYCLE_TICKS_RST    = 32'd1000;
    localparam logic [TIME_W-1:0] MAX_HOLD_TICKS_RST = 32'd0;
    localparam logic              DEFAULT_LEVEL_RST  = 1'b0;
    localparam logic              INITIAL_LEVEL_RST  = 1'b0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE_TICKS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_HOLD_TICKS = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_LEVEL  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_LEVEL  = 8'd3;

    // item kinds
    localparam logic REQ_TICK     = 1'b0;
    localparam logic REQ_SCHEDULE = 1'b1;

    // mode flag bits
    localparam int F_ON   = 0;
    localparam int F_TOG  = 1;
    localparam int F_CHK  = 2;
    localparam int F_HAVE = 3;
    localparam int F_NON  = 4;
    localparam int F_NTOG = 5;
    localparam int F_NCHK = 6;

    localparam logic [MODE_W-1:0] CUR_MASK   = 7'h0f;
    localparam int                NEXT_SHIFT = 4;

    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_MISSED  = 2'd1,
        ERR_OVERLAP = 2'd2
    } err_t;

    // a before b when (a - b) is negative as a signed value
    function automatic logic is_before(input logic [TIME_W-1:0] a,
                                       input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

`default_nettype wire

[design/scheduled_pwm_generator_unit.sv]
// Accepted input words pass the input stage, then the result stage, to m_tvalid.
// Throughput: 1 word per cycle unless m_tready stalls; state takes one reg-to-reg pass.
// s_tready falls only while both stages hold words and m_tready is low.
// Reset: synchronous, active-low aresetn; clears timing state and valid flags,
// restores register defaults (period 1000 ticks, no hold check, levels low).
// ----------------------------------------------------------------------------
// Scheduled PWM generator
// Tick/schedule driven PWM pin with wrap-aware 32-bit timebase and sticky faults.
// ----------------------------------------------------------------------------
`default_nettype none

module scheduled_pwm_generator_unit (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output      logic                           s_tready,
    input  wire logic [2*spg_pkg::TIME_W-1:0]   s_tdata,  // start_time, on_ticks
    input  wire logic                           s_tuser,  // req_type
    output      logic                           m_tvalid,
    input  wire logic                           m_tready,
    output      logic [spg_pkg::OUT_W-1:0]      m_tdata,  // pin_level, error_code,
                                                          // timer_armed, zero pad
    input  wire logic                           cfg_valid,
    output      logic                           cfg_ready,
    input  wire logic [spg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [spg_pkg::TIME_W-1:0]     cfg_data
);

    localparam int TW = spg_pkg::TIME_W;
    localparam int MW = spg_pkg::MODE_W;

    // configuration
    logic [TW-1:0] cycle_reg, max_hold_reg;
    logic          dflt_reg, init_reg;

    // input stage
    logic          in_valid_reg;
    logic          in_req_reg;
    logic [TW-1:0] in_start_reg, in_on_reg;

    // result stage
    logic                        out_valid_reg;
    logic [spg_pkg::OUT_W-1:0]   out_data_reg;

    // timing state
    logic [TW-1:0] now_reg, wake_reg, end_reg, high_reg, low_reg, st_high_reg, st_low_reg;
    logic [TW-1:0] now_next, wake_next, end_next, high_next, low_next;
    logic [TW-1:0] st_high_next, st_low_next;
    logic [MW-1:0] mode_reg, mode_next;
    logic          armed_reg, armed_next, ev_load_reg, ev_load_next, level_reg, level_next;
    spg_pkg::err_t fault_reg, fault_next;
    logic [TW-1:0] cycle_next, max_hold_next;
    logic          dflt_next, init_next;

    logic advance, proc, in_fire, cfg_fire, idle;

    // tick datapath
    logic [TW-1:0] now_inc, tog_wake, load_wake, load_end;
    logic          due, tog_on;
    logic [2:0]    nxt_flags;

    // schedule datapath
    logic          on_zero, sched_big, sched_overlap, sched_keep;
    logic [TW-1:0] sched_off;
    logic [MW-1:0] sched_nf, sched_mode;

    assign advance   = !out_valid_reg || m_tready;
    assign proc      = in_valid_reg && advance;
    assign s_tready  = !in_valid_reg || advance;
    assign in_fire   = s_tvalid && s_tready;
    assign cfg_ready = !in_valid_reg;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign idle      = !armed_reg && (fault_reg == spg_pkg::ERR_NONE);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign now_inc   = now_reg + 32'd1;
    assign due       = (fault_reg == spg_pkg::ERR_NONE) && armed_reg
                       && !spg_pkg::is_before(now_inc, wake_reg);
    assign tog_on    = ~mode_reg[spg_pkg::F_ON];
    assign tog_wake  = wake_reg + (tog_on ? high_reg : low_reg);
    assign nxt_flags = mode_reg[spg_pkg::NEXT_SHIFT +: 3];
    assign load_wake = end_reg + st_high_reg;
    assign load_end  = end_reg + max_hold_reg;

    assign on_zero       = (in_on_reg == '0);
    assign sched_big     = on_zero || (in_on_reg >= cycle_reg);
    assign sched_off     = cycle_reg - in_on_reg;
    assign sched_overlap = mode_reg[spg_pkg::F_CHK]
                           && spg_pkg::is_before(end_reg, in_start_reg);
    assign sched_keep    = mode_reg[spg_pkg::F_TOG] && armed_reg
                           && spg_pkg::is_before(wake_reg, in_start_reg);
    assign sched_mode    = (mode_reg & spg_pkg::CUR_MASK) | sched_nf;

    always_comb begin
        sched_nf = '0;
        sched_nf[spg_pkg::F_CHK]  = 1'b1;
        sched_nf[spg_pkg::F_HAVE] = 1'b1;
        if (sched_big) begin
            sched_nf[spg_pkg::F_NON]  = !on_zero;
            sched_nf[spg_pkg::F_NCHK] = ((!on_zero) != dflt_reg) && (max_hold_reg != '0);
        end else begin
            sched_nf[spg_pkg::F_NON]  = 1'b1;
            sched_nf[spg_pkg::F_NTOG] = 1'b1;
            sched_nf[spg_pkg::F_NCHK] = (max_hold_reg != '0);
        end
    end

    always_comb begin
        now_next      = now_reg;
        wake_next     = wake_reg;
        end_next      = end_reg;
        high_next     = high_reg;
        low_next      = low_reg;
        st_high_next  = st_high_reg;
        st_low_next   = st_low_reg;
        mode_next     = mode_reg;
        armed_next    = armed_reg;
        ev_load_next  = ev_load_reg;
        level_next    = level_reg;
        fault_next    = fault_reg;
        cycle_next    = cycle_reg;
        max_hold_next = max_hold_reg;
        dflt_next     = dflt_reg;
        init_next     = init_reg;
        if (proc) begin
            if (in_req_reg == spg_pkg::REQ_TICK) begin
                now_next = now_inc;
                if (due) begin
                    if (ev_load_reg) begin
                        if (!mode_reg[spg_pkg::F_HAVE]) begin
                            fault_next = spg_pkg::ERR_MISSED;
                            armed_next = 1'b0;
                        end else begin
                            mode_next  = {{(MW-3){1'b0}}, nxt_flags};
                            level_next = nxt_flags[spg_pkg::F_ON];
                            if (!nxt_flags[spg_pkg::F_TOG]) begin
                                if (!nxt_flags[spg_pkg::F_CHK]) begin
                                    armed_next = 1'b0;
                                end else begin
                                    end_next  = load_end;
                                    wake_next = load_end;
                                end
                            end else begin
                                ev_load_next = 1'b0;
                                low_next     = st_low_reg;
                                high_next    = st_high_reg;
                                wake_next    = load_wake;
                                end_next     = load_end;
                            end
                        end
                    end else begin
                        level_next                = ~level_reg;
                        mode_next[spg_pkg::F_ON]  = tog_on;
                        wake_next                 = tog_wake;
                        if (mode_reg[spg_pkg::F_CHK]
                            && !spg_pkg::is_before(tog_wake, end_reg)) begin
                            ev_load_next = 1'b1;
                            wake_next    = end_reg;
                        end
                    end
                end
            end else if (fault_reg == spg_pkg::ERR_NONE) begin
                if (sched_overlap) begin
                    fault_next = spg_pkg::ERR_OVERLAP;
                    armed_next = 1'b0;
                end else begin
                    end_next     = in_start_reg;
                    st_high_next = sched_big ? '0 : in_on_reg;
                    st_low_next  = sched_big ? '0 : sched_off;
                    mode_next    = sched_mode;
                    if (!sched_keep) begin
                        wake_next    = in_start_reg;
                        ev_load_next = 1'b1;
                        armed_next   = 1'b1;
                    end
                end
            end
        end else if (cfg_fire) begin
            unique case (cfg_index)
                spg_pkg::REG_CYCLE_TICKS:    cycle_next    = cfg_data;
                spg_pkg::REG_MAX_HOLD_TICKS: max_hold_next = cfg_data;
                spg_pkg::REG_DEFAULT_LEVEL: begin
                    dflt_next = cfg_data[0];
                    if (idle) begin
                        mode_next[spg_pkg::F_ON] = cfg_data[0];
                    end
                end
                spg_pkg::REG_INITIAL_LEVEL: begin
                    init_next = cfg_data[0];
                    if (idle) begin
                        level_next = cfg_data[0];
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cycle_reg     <= spg_pkg::CYCLE_TICKS_RST;
            max_hold_reg  <= spg_pkg::MAX_HOLD_TICKS_RST;
            dflt_reg      <= spg_pkg::DEFAULT_LEVEL_RST;
            init_reg      <= spg_pkg::INITIAL_LEVEL_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            now_reg       <= '0;
            wake_reg      <= '0;
            end_reg       <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            st_high_reg   <= '0;
            st_low_reg    <= '0;
            mode_reg      <= {{(MW-1){1'b0}}, spg_pkg::DEFAULT_LEVEL_RST};
            armed_reg     <= 1'b0;
            ev_load_reg   <= 1'b1;
            level_reg     <= spg_pkg::INITIAL_LEVEL_RST;
            fault_reg     <= spg_pkg::ERR_NONE;
        end else begin
            cycle_reg    <= cycle_next;
            max_hold_reg <= max_hold_next;
            dflt_reg     <= dflt_next;
            init_reg     <= init_next;
            now_reg      <= now_next;
            wake_reg     <= wake_next;
            end_reg      <= end_next;
            high_reg     <= high_next;
            low_reg      <= low_next;
            st_high_reg  <= st_high_next;
            st_low_reg   <= st_low_next;
            mode_reg     <= mode_next;
            armed_reg    <= armed_next;
            ev_load_reg  <= ev_load_next;
            level_reg    <= level_next;
            fault_reg    <= fault_next;
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_req_reg   <= s_tuser;
            in_start_reg <= s_tdata[TW-1:0];
            in_on_reg    <= s_tdata[2*TW-1:TW];
        end
        if (proc) begin
            out_data_reg <= {{(spg_pkg::OUT_W-4){1'b0}}, armed_next, fault_next, level_next};
        end
    end

endmodule

`default_nettype wire

[design/scheduled_pwm_generator_unit_checker.sv]
// ----------------------------------------------------------------------------
// Scheduled PWM generator port checker
// Watches the result channel of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scheduled_pwm_generator_unit_defines.svh"

module scheduled_pwm_generator_unit_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       m_tvalid,
    input wire logic                       m_tready,
    input wire logic [spg_pkg::OUT_W-1:0]  m_tdata
);

    `SPG_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "word moved")
    `SPG_ASSERT(a_err_code, m_tvalid |-> m_tdata[2:1] <= spg_pkg::ERR_OVERLAP, "bad error code")
    `SPG_ASSERT(a_fault_disarms, m_tvalid && m_tdata[2:1] != spg_pkg::ERR_NONE |-> !m_tdata[3], "armed")
    `SPG_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_tvalid, "result word right after reset")

endmodule

bind scheduled_pwm_generator_unit scheduled_pwm_generator_unit_checker u_checker (.*);

`default_nettype wire

[test/scheduled_pwm_generator_unit_test.sv]
// ----------------------------------------------------------------------------
// Scheduled PWM generator testbench
// Drives tick and schedule words into the block, predicts every result word
// from a model of the timebase, toggle/load events and sticky faults, and
// compares each result field by field. Runs a directed pass, randomised
// register settings with well-formed renewal sequences, an output hold-off
// that backs up the input, and finally a sticky fault.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scheduled_pwm_generator_unit_test;

    localparam int          CLK_HALF     = 4;
    localparam int          RESET_CYCLES = 7;
    localparam int          DRAIN_CYCLES = 4;
    localparam int          LONG_HOLD    = 150;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int          PHASES       = 11;
    localparam int          PHASE_WORDS  = 120;
    localparam int          TW           = spg_pkg::TIME_W;
    localparam int          MW           = spg_pkg::MODE_W;

    localparam logic [MW-1:0] NEXT_MASK = 7'h07;

    typedef struct packed {
        logic          pin;
        spg_pkg::err_t err;
        logic          armed;
    } pin_word_t;

    logic                            aclk;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [2*TW-1:0]                 s_tdata   = '0;
    logic                            s_tuser   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b1;
    logic [spg_pkg::OUT_W-1:0]       m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [spg_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [TW-1:0]                   cfg_data  = '0;

    // register copies
    logic [TW-1:0] cfg_cycle;
    logic [TW-1:0] cfg_hold;
    logic          cfg_dflt;
    logic          cfg_init;

    // timebase and event state
    logic [TW-1:0] pwm_now;
    logic [TW-1:0] pwm_wake;
    logic [TW-1:0] pwm_end;
    logic [TW-1:0] pwm_high;
    logic [TW-1:0] pwm_low;
    logic [TW-1:0] pwm_stg_high;
    logic [TW-1:0] pwm_stg_low;
    logic [MW-1:0] pwm_mode;
    logic          pwm_armed;
    logic          pwm_load_due;
    logic          pwm_pin;
    spg_pkg::err_t pwm_fault;

    pin_word_t   expected_pin_words[$];
    pin_word_t   due_word;
    int          fail_count    = 0;
    int          words_checked = 0;
    int          tick_count    = 0;
    int          sched_count   = 0;
    int          setting_count = 0;
    int unsigned cycle_count   = 0;
    bit          src_gaps      = 1'b1;
    bit          sink_stalls   = 1'b1;
    bit          long_hold_req = 1'b0;

    scheduled_pwm_generator_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("scheduled_pwm_generator_unit_test: done, errors");
            $finish;
        end
    end

    // wrap-aware time order
    function automatic logic precedes(input logic [TW-1:0] a, input logic [TW-1:0] b);
        logic [TW-1:0] diff;
        diff = a - b;
        return diff[TW-1];
    endfunction

    function automatic void reset_pwm_state();
        cfg_cycle    = spg_pkg::CYCLE_TICKS_RST;
        cfg_hold     = spg_pkg::MAX_HOLD_TICKS_RST;
        cfg_dflt     = spg_pkg::DEFAULT_LEVEL_RST;
        cfg_init     = spg_pkg::INITIAL_LEVEL_RST;
        pwm_now      = '0;
        pwm_wake     = '0;
        pwm_end      = '0;
        pwm_high     = '0;
        pwm_low      = '0;
        pwm_stg_high = '0;
        pwm_stg_low  = '0;
        pwm_mode     = '0;
        pwm_mode[spg_pkg::F_ON] = cfg_dflt;
        pwm_armed    = 1'b0;
        pwm_load_due = 1'b1;
        pwm_pin      = cfg_init;
        pwm_fault    = spg_pkg::ERR_NONE;
    endfunction

    function automatic void apply_reg_write(input logic [spg_pkg::CFG_IDX_W-1:0] idx,
                                            input logic [TW-1:0] val);
        logic quiet;
        quiet = !pwm_armed && pwm_fault == spg_pkg::ERR_NONE;
        case (idx)
            spg_pkg::REG_CYCLE_TICKS:    cfg_cycle = val;
            spg_pkg::REG_MAX_HOLD_TICKS: cfg_hold = val;
            spg_pkg::REG_DEFAULT_LEVEL: begin
                cfg_dflt = val[0];
                if (quiet) pwm_mode[spg_pkg::F_ON] = cfg_dflt;
            end
            spg_pkg::REG_INITIAL_LEVEL: begin
                cfg_init = val[0];
                if (quiet) pwm_pin = cfg_init;
            end
            default: ;
        endcase
    endfunction

    function automatic pin_word_t predict_pin_word(input logic req,
                                                   input logic [TW-1:0] start,
                                                   input logic [TW-1:0] on);
        logic [TW-1:0] w;
        logic [TW-1:0] hi;
        logic [TW-1:0] lo;
        logic [MW-1:0] nf;
        pin_word_t     r;
        if (req == spg_pkg::REQ_TICK) begin
            pwm_now = pwm_now + 1;
            if (pwm_fault == spg_pkg::ERR_NONE && pwm_armed
                && !precedes(pwm_now, pwm_wake)) begin
                if (!pwm_load_due) begin
                    w = pwm_wake;
                    pwm_pin = ~pwm_pin;
                    pwm_mode[spg_pkg::F_ON] = ~pwm_mode[spg_pkg::F_ON];
                    w = w + (pwm_mode[spg_pkg::F_ON] ? pwm_high : pwm_low);
                    if (pwm_mode[spg_pkg::F_CHK] && !precedes(w, pwm_end)) begin
                        pwm_load_due = 1'b1;
                        w = pwm_end;
                    end
                    pwm_wake = w;
                end else if (!pwm_mode[spg_pkg::F_HAVE]) begin
                    pwm_fault = spg_pkg::ERR_MISSED;
                    pwm_armed = 1'b0;
                end else begin
                    pwm_mode = (pwm_mode >> spg_pkg::NEXT_SHIFT) & NEXT_MASK;
                    pwm_pin  = pwm_mode[spg_pkg::F_ON];
                    if (pwm_mode[spg_pkg::F_TOG]) begin
                        pwm_load_due = 1'b0;
                        pwm_low  = pwm_stg_low;
                        pwm_high = pwm_stg_high;
                        pwm_wake = pwm_end + pwm_high;
                        pwm_end  = pwm_end + cfg_hold;
                    end else if (pwm_mode[spg_pkg::F_CHK]) begin
                        pwm_end  = pwm_end + cfg_hold;
                        pwm_wake = pwm_end;
                    end else begin
                        pwm_armed = 1'b0;
                    end
                end
            end
        end else if (pwm_fault == spg_pkg::ERR_NONE) begin
            nf = '0;
            nf[spg_pkg::F_CHK]  = 1'b1;
            nf[spg_pkg::F_HAVE] = 1'b1;
            if (on == 0 || on >= cfg_cycle) begin
                nf[spg_pkg::F_NON]  = (on != 0);
                nf[spg_pkg::F_NCHK] = ((on != 0) != cfg_dflt) && cfg_hold != 0;
                hi = '0;
                lo = '0;
            end else begin
                hi = on;
                lo = cfg_cycle - on;
                nf[spg_pkg::F_NON]  = 1'b1;
                nf[spg_pkg::F_NTOG] = 1'b1;
                nf[spg_pkg::F_NCHK] = (cfg_hold != 0);
            end
            if (pwm_mode[spg_pkg::F_CHK] && precedes(pwm_end, start)) begin
                pwm_fault = spg_pkg::ERR_OVERLAP;
                pwm_armed = 1'b0;
            end else begin
                pwm_end      = start;
                pwm_stg_high = hi;
                pwm_stg_low  = lo;
                pwm_mode     = (pwm_mode & spg_pkg::CUR_MASK) | nf;
                // running toggles hand over at the end mark
                if (!(pwm_mode[spg_pkg::F_TOG] && pwm_armed && precedes(pwm_wake, start))) begin
                    pwm_wake     = start;
                    pwm_load_due = 1'b1;
                    pwm_armed    = 1'b1;
                end
            end
        end
        r.pin   = pwm_pin;
        r.err   = pwm_fault;
        r.armed = pwm_armed;
        return r;
    endfunction

    // next tick would fire a load with nothing staged
    function automatic bit tick_would_miss();
        return pwm_fault == spg_pkg::ERR_NONE && pwm_armed && pwm_load_due
               && !pwm_mode[spg_pkg::F_HAVE] && !precedes(pwm_now + 1, pwm_wake);
    endfunction

    function automatic logic [TW-1:0] clamp_to_end_mark(input logic [TW-1:0] cand);
        if (pwm_mode[spg_pkg::F_CHK] && precedes(pwm_end, cand))
            return pwm_end - $urandom_range(0, 3);
        return cand;
    endfunction

    function automatic logic [TW-1:0] pick_start_time();
        case ($urandom_range(0, 9))
            0:       return clamp_to_end_mark($urandom());
            1:       return clamp_to_end_mark(pwm_now - $urandom_range(0, 20));
            default: return clamp_to_end_mark(pwm_now + $urandom_range(0, 40));
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_on_ticks();
        logic [TW-1:0] top;
        top = (cfg_cycle > 41) ? 32'd40 : cfg_cycle - 1;
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return cfg_cycle;
            2:       return '1;
            3:       return $urandom();
            4:       return cfg_cycle + $urandom_range(1, 50);
            5:       return (cfg_cycle > 1) ? $urandom_range(1, cfg_cycle - 1) : 32'd1;
            default: return (cfg_cycle > 1) ? $urandom_range(1, top) : $urandom_range(1, 5);
        endcase
    endfunction

    task automatic offer_word(input logic req, input logic [TW-1:0] start,
                              input logic [TW-1:0] on);
        if (src_gaps && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {on, start};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_pin_words.push_back(predict_pin_word(req, start, on));
        if (req == spg_pkg::REQ_TICK) tick_count++;
        else sched_count++;
    endtask

    task automatic write_reg(input logic [spg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [TW-1:0] val, input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (last) cfg_valid <= 1'b0;
        apply_reg_write(idx, val);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_pin_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic random_step(input int sched_pct);
        if (tick_would_miss() || $urandom_range(0, 99) < sched_pct)
            offer_word(spg_pkg::REQ_SCHEDULE, pick_start_time(), pick_on_ticks());
        else
            offer_word(spg_pkg::REQ_TICK, $urandom(), $urandom());
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pin_words.size() == 0) begin
                $error("result word %h with nothing expected", m_tdata);
                fail_count++;
            end else begin
                due_word = expected_pin_words.pop_front();
                words_checked++;
                if (m_tdata[0] !== due_word.pin) begin
                    $error("pin_level: expected %0d, got %0d", due_word.pin, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[2:1] !== due_word.err) begin
                    $error("error_code: expected %0d, got %0d", due_word.err, m_tdata[2:1]);
                    fail_count++;
                end
                if (m_tdata[3] !== due_word.armed) begin
                    $error("timer_armed: expected %0d, got %0d", due_word.armed, m_tdata[3]);
                    fail_count++;
                end
            end
        end
    end

    // result sink: random stalls, plus one long hold-off on request
    initial begin : sink_ctrl
        int hold_count;
        forever begin
            @(posedge aclk);
            if (long_hold_req) begin
                m_tready <= 1'b0;
                for (hold_count = 0; hold_count < LONG_HOLD; hold_count++) @(posedge aclk);
                long_hold_req = 1'b0;
                m_tready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_directed();
        write_reg(spg_pkg::REG_CYCLE_TICKS, 32'd4, 1'b0);
        write_reg(spg_pkg::REG_MAX_HOLD_TICKS, 32'd0, 1'b0);
        write_reg(spg_pkg::REG_DEFAULT_LEVEL, 32'd0, 1'b0);
        write_reg(spg_pkg::REG_INITIAL_LEVEL, 32'd1, 1'b1);
        setting_count++;
        offer_word(spg_pkg::REQ_TICK, '1, '1);
        offer_word(spg_pkg::REQ_SCHEDULE, pwm_now + 2, 32'd1);
        repeat (6) offer_word(spg_pkg::REQ_TICK, '0, '0);
        // start times at both ends of the range, both already past
        offer_word(spg_pkg::REQ_SCHEDULE, '0, '1);
        repeat (2) offer_word(spg_pkg::REQ_TICK, '0, '0);
        offer_word(spg_pkg::REQ_SCHEDULE, '1, '0);
        offer_word(spg_pkg::REQ_TICK, '1, '1);
        // past start: load, then a toggle due straight away
        offer_word(spg_pkg::REQ_SCHEDULE, pwm_now - 3, 32'd3);
        repeat (4) offer_word(spg_pkg::REQ_TICK, '0, '0);
        wait_drained();
        write_reg(spg_pkg::REG_CYCLE_TICKS, 32'd0, 1'b1);
        setting_count++;
        offer_word(spg_pkg::REQ_SCHEDULE, pwm_now + 1, 32'd5);
        repeat (2) offer_word(spg_pkg::REQ_TICK, '0, '0);
        // level writes while armed only touch the registers
        offer_word(spg_pkg::REQ_SCHEDULE, pwm_now + 500, 32'd2);
        wait_drained();
        write_reg(spg_pkg::REG_DEFAULT_LEVEL, 32'd1, 1'b0);
        write_reg(spg_pkg::REG_INITIAL_LEVEL, 32'd0, 1'b1);
        offer_word(spg_pkg::REQ_SCHEDULE, pwm_now, 32'd0);
        offer_word(spg_pkg::REQ_TICK, '0, '0);
        wait_drained();
        write_reg(spg_pkg::REG_DEFAULT_LEVEL, 32'd1, 1'b0);
        write_reg(spg_pkg::REG_INITIAL_LEVEL, 32'd1, 1'b1);
        offer_word(spg_pkg::REQ_TICK, '0, '0);
        wait_drained();
    endtask

    task automatic test_random_settings();
        int            phase;
        int            n;
        int            sched_pct;
        logic [TW-1:0] cyc;
        logic [TW-1:0] hold;
        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       cyc = 32'd1;
                1:       cyc = '1;
                2:       cyc = 32'd0;
                3:       cyc = 32'h8000_0000;
                default: cyc = $urandom_range(2, 16);
            endcase
            case (phase % 4)
                0:       hold = '0;
                1:       hold = $urandom_range(1, 60);
                2:       hold = '1;
                default: hold = $urandom_range(5, 30);
            endcase
            write_reg(spg_pkg::REG_CYCLE_TICKS, cyc, 1'b0);
            write_reg(spg_pkg::REG_MAX_HOLD_TICKS, hold, 1'b0);
            write_reg(spg_pkg::REG_DEFAULT_LEVEL, $urandom_range(0, 1), 1'b0);
            write_reg(spg_pkg::REG_INITIAL_LEVEL, $urandom_range(0, 1), 1'b1);
            setting_count++;
            src_gaps    = (phase % 4 != 0);
            sink_stalls = (phase % 4 != 0);
            sched_pct   = $urandom_range(5, 35);
            for (n = 0; n < PHASE_WORDS; n++) random_step(sched_pct);
        end
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    task automatic test_input_backpressure();
        wait_drained();
        src_gaps = 1'b0;
        long_hold_req = 1'b1;
        repeat (40) random_step(20);
        wait_drained();
        src_gaps = 1'b1;
    endtask

    task automatic test_sticky_fault();
        int guard;
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        wait_drained();
        write_reg(spg_pkg::REG_CYCLE_TICKS, 32'd6, 1'b0);
        write_reg(spg_pkg::REG_MAX_HOLD_TICKS, 32'd20, 1'b1);
        setting_count++;
        repeat (30) random_step(20);
        if ($urandom_range(0, 1) == 1) begin
            offer_word(spg_pkg::REQ_SCHEDULE, clamp_to_end_mark(pwm_now + 5), 32'd3);
            offer_word(spg_pkg::REQ_SCHEDULE, pwm_end + $urandom_range(1, 100), $urandom());
        end else begin
            // toggling setting left to run past its end mark unrenewed
            offer_word(spg_pkg::REQ_SCHEDULE, clamp_to_end_mark(pwm_now + 2), 32'd3);
            for (guard = 0; guard < 200 && pwm_fault == spg_pkg::ERR_NONE; guard++)
                offer_word(spg_pkg::REQ_TICK, $urandom(), $urandom());
        end
        repeat (12) random_step(30);
        wait_drained();
        write_reg(spg_pkg::REG_DEFAULT_LEVEL, {{(TW-1){1'b0}}, ~cfg_dflt}, 1'b0);
        write_reg(spg_pkg::REG_INITIAL_LEVEL, {{(TW-1){1'b0}}, ~cfg_init}, 1'b1);
        repeat (6) random_step(30);
        wait_drained();
    endtask

    initial begin
        reset_pwm_state();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_settings();
        test_input_backpressure();
        test_sticky_fault();
        $display("covered %0d ticks and %0d schedules over %0d register settings, %0d words",
                 tick_count, sched_count, setting_count, words_checked);
        $display("run closed on a sticky %s fault after a long output hold-off",
                 pwm_fault.name());
        if (fail_count == 0) begin
            $display("scheduled_pwm_generator_unit_test: done, clean");
        end else begin
            $display("scheduled_pwm_generator_unit_test: done, errors");
        end
        $finish;
    end

endmodule
